// File: rtl/core/calendar_date_stepper_defines.svh
// Assertion macros used by the checker file of the date stepper.
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after a reset cycle.
`define CDS_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cds_pkg.sv
`default_nettype none

package cds_pkg;

  localparam int DATE_W = 27;
  localparam int YEAR_W = 14;
  localparam int HALF_W = 7;   // century or year-of-century, 0..99
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_DATE     = 2'd0;
  localparam logic [1:0] STAT_LOAD_OK  = 2'd1;
  localparam logic [1:0] STAT_LOAD_REJ = 2'd2;

  // reciprocal of 10000 scaled by 2**40, rounded down (quotient may be one low)
  localparam logic [DATE_W-1:0] RECIP_10K   = 27'd109951162;
  localparam int                RECIP_10K_S = 40;
  // reciprocal of 100 scaled by 2**19, rounded up (exact below 43690)
  localparam logic [12:0]       RECIP_100   = 13'd5243;
  localparam int                RECIP_100_S = 19;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  // reset date 2000-01-01
  localparam logic [HALF_W-1:0] RST_CENT = 7'd20;
  localparam logic [HALF_W-1:0] RST_YOC  = 7'd0;
  localparam logic [MON_W-1:0]  RST_MON  = 4'd1;
  localparam logic [DAY_W-1:0]  RST_DAY  = 5'd1;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              kind;
    logic              ok;      // load fields passed the range checks
    logic [HALF_W-1:0] cent;
    logic [HALF_W-1:0] yoc;
    logic [MON_W-1:0]  mon;
    logic [DAY_W-1:0]  day;
  } cds_item_t;

endpackage

`default_nettype wire

// File: rtl/core/cds_front.sv
`default_nettype none

module cds_front
  import cds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  input  wire logic [DATE_W-1:0] start_date,
  input  wire logic              q_full,
  output logic                   push,
  output cds_item_t              push_item
);

  logic en;

  // stage 1: captured item
  logic              s1_valid;
  logic              s1_kind;
  logic [DATE_W-1:0] s1_date;
  // stage 2: estimated year
  logic              s2_valid;
  logic              s2_kind;
  logic [DATE_W-1:0] s2_date;
  logic [YEAR_W-1:0] s2_qest;
  // stage 3: exact year and month-day remainder
  logic              s3_valid;
  logic              s3_kind;
  logic [YEAR_W-1:0] s3_year;
  logic [YEAR_W-1:0] s3_rem;
  // stage 4: hundreds of both
  logic              s4_valid;
  logic              s4_kind;
  logic [YEAR_W-1:0] s4_year;
  logic [YEAR_W-1:0] s4_rem;
  logic [7:0]        s4_cent;
  logic [7:0]        s4_mon;

  logic [2*DATE_W-1:0] prod1;
  logic [2*YEAR_W-1:0] prod2;
  logic [2*YEAR_W-1:0] rem_wide;
  logic                rem_over;
  logic [26:0]         prod_yc;
  logic [26:0]         prod_rm;
  logic [14:0]         cent_x100;
  logic [14:0]         mon_x100;
  logic [YEAR_W-1:0]   yoc_full;
  logic [YEAR_W-1:0]   day_full;
  logic                load_ok;

  // hold the whole pipe while the last stage has nowhere to go
  assign en       = !(s4_valid && q_full);
  assign in_ready = en;
  assign push     = s4_valid && en;

  assign prod1    = s1_date * RECIP_10K;
  assign prod2    = s2_qest * YEAR_W'(10000);
  assign rem_wide = {1'b0, s2_date} - prod2;
  assign rem_over = rem_wide >= 28'd10000;
  assign prod_yc  = s3_year * RECIP_100;
  assign prod_rm  = s3_rem * RECIP_100;

  assign cent_x100 = s4_cent * 7'd100;
  assign mon_x100  = s4_mon * 7'd100;
  assign yoc_full  = s4_year - cent_x100[YEAR_W-1:0];
  assign day_full  = s4_rem - mon_x100[YEAR_W-1:0];

  always_comb begin
    load_ok = (s4_year <= YEAR_MAX)
           && (s4_mon inside {[8'd1:8'd12]})
           && (day_full inside {[14'd1:14'd31]});
    push_item.kind = s4_kind;
    push_item.ok   = load_ok;
    push_item.cent = s4_cent[HALF_W-1:0];
    push_item.yoc  = yoc_full[HALF_W-1:0];
    push_item.mon  = s4_mon[MON_W-1:0];
    push_item.day  = day_full[DAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind <= kind;
      s1_date <= start_date;

      s2_kind <= s1_kind;
      s2_date <= s1_date;
      s2_qest <= prod1[RECIP_10K_S +: YEAR_W];

      // estimate is exact or one low: correct it once
      s3_kind <= s2_kind;
      s3_year <= s2_qest + YEAR_W'(rem_over);
      s3_rem  <= rem_over ? YEAR_W'(rem_wide - 28'd10000) : rem_wide[YEAR_W-1:0];

      s4_kind <= s3_kind;
      s4_year <= s3_year;
      s4_rem  <= s3_rem;
      s4_cent <= prod_yc[RECIP_100_S +: 8];
      s4_mon  <= prod_rm[RECIP_100_S +: 8];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cds_queue.sv
`default_nettype none

module cds_queue
  import cds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cds_item_t push_item,
  output logic           full,
  output logic           q_valid,
  output cds_item_t      q_item,
  input  wire logic      pop
);

  cds_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QDEPTH);
  assign q_valid = count != '0;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

// File: rtl/core/cds_back.sv
`default_nettype none

module cds_back
  import cds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire cds_item_t         q_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATE_W-1:0]      date_out,
  output logic [1:0]             status
);

  logic [HALF_W-1:0] cent;
  logic [HALF_W-1:0] yoc;
  logic [MON_W-1:0]  mon;
  logic [DAY_W-1:0]  day;

  logic              leap;
  logic [DAY_W-1:0]  mon_len;
  logic              day_roll;
  logic              mon_roll;
  logic              yoc_roll;
  logic [DATE_W-1:0] packed_date;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    leap = (yoc[1:0] == 2'd0) && ((yoc != '0) || (cent[1:0] == 2'd0));
    if (mon == MON_W'(2))        mon_len = leap ? DAY_W'(29) : DAY_W'(28);
    else if (mon[0] ^ mon[3])    mon_len = DAY_W'(31);
    else                         mon_len = DAY_W'(30);
    day_roll = day >= mon_len;
    mon_roll = mon == MON_W'(12);
    yoc_roll = yoc == HALF_W'(99);
    packed_date = DATE_W'(cent) * DATE_W'(1000000) + DATE_W'(yoc) * DATE_W'(10000)
                + DATE_W'(mon) * DATE_W'(100) + DATE_W'(day);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cent      <= RST_CENT;
      yoc       <= RST_YOC;
      mon       <= RST_MON;
      day       <= RST_DAY;
    end else begin
      if (pop)            out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (pop && q_item.kind == KIND_LOAD && q_item.ok) begin
        cent <= q_item.cent;
        yoc  <= q_item.yoc;
        mon  <= q_item.mon;
        day  <= q_item.day;
      end else if (pop && q_item.kind == KIND_ADVANCE) begin
        if (!day_roll) begin
          day <= day + 1'b1;
        end else begin
          day <= DAY_W'(1);
          if (!mon_roll) begin
            mon <= mon + 1'b1;
          end else begin
            mon <= MON_W'(1);
            if (!yoc_roll) begin
              yoc <= yoc + 1'b1;
            end else begin
              yoc  <= '0;
              cent <= (cent == HALF_W'(99)) ? '0 : cent + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_item.kind == KIND_ADVANCE) begin
        date_out <= packed_date;
        status   <= STAT_DATE;
      end else begin
        date_out <= '0;
        status   <= q_item.ok ? STAT_LOAD_OK : STAT_LOAD_REJ;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/calendar_date_stepper.sv
// Gregorian date stepper. Send kind=0 with start_date as decimal yyyymmdd to
// load a date (status 1), or get status 2 with no change when the month is
// outside 1..12, the day outside 1..31 or the year above 9999. Send kind=1 to
// receive the held date in date_out (status 0) and step it one day; a day too
// large for its month is returned once and then rolls to the first of the
// next month, and 9999-12-31 wraps to year 0. After reset the date is
// 2000-01-01. Throughput is one item per clock with out_ready high; an item
// passes through the four decode stages, the queue and the output register
// on its way to the result. The input side stalls only when the last decode
// stage holds an item and the four-entry queue is full.
`default_nettype none

module calendar_date_stepper
  import cds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  input  wire logic [DATE_W-1:0] start_date,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATE_W-1:0]      date_out,
  output logic [1:0]             status
);

  logic      push;
  cds_item_t push_item;
  logic      q_full;
  logic      q_valid;
  cds_item_t q_item;
  logic      pop;

  // Front: split the packed decimal date into century, year of century,
  // month and day, and classify each load as good or rejected.
  cds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .start_date (start_date),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Queue: absorb decoded items so the front keeps moving while results
  // wait to be taken.
  cds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Back: hold the date, apply loads, emit and advance, and drive the
  // output register.
  cds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .date_out  (date_out),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: rtl/core/cds_checker.sv
`default_nettype none

`include "calendar_date_stepper_defines.svh"

module cds_checker
  import cds_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATE_W-1:0] date_out,
  input wire logic [1:0]        status
);

  `CDS_ASSERT_RESET(a_reset_clears, !out_valid, "result valid right after reset")
  `CDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(date_out) && $stable(status),
                   "stalled result changed")
  `CDS_ASSERT_IMP(a_status_code, out_valid, status <= STAT_LOAD_REJ, "unknown status code")
  `CDS_ASSERT_IMP(a_load_zero, out_valid && status != STAT_DATE, date_out == '0,
                  "load result carries a date")

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .date_out  (date_out),
  .status    (status)
);

`default_nettype wire

// File: test/calendar_date_stepper_test.sv
`timescale 1ns / 1ps

module calendar_date_stepper_test
  import cds_pkg::*;
();

  // Result of one transfer as it should leave the block.
  typedef struct {
    logic [DATE_W-1:0] date;
    logic [1:0]        stat;
  } cal_result_t;

  // One line of the directed script; the expectation is only used when typed.
  typedef struct {
    logic              kind;
    logic [DATE_W-1:0] word;
    bit                typed;
    logic [DATE_W-1:0] exp_date;
    logic [1:0]        exp_stat;
  } script_row_t;

  localparam int RANDOM_ITEMS = 900;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_LOAD;
  logic [DATE_W-1:0] start_date = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATE_W-1:0] date_out;
  logic [1:0]        status;

  // Shadow calendar, stepped in lockstep with accepted transfers.
  int unsigned cal_year  = 2000;
  int unsigned cal_month = 1;
  int unsigned cal_day   = 1;

  cal_result_t due_results[$];
  script_row_t script[$];

  bit steady = 1'b0;   // suppress all idling on both sides
  int mismatches   = 0;
  int dates_seen   = 0;
  int loads_taken  = 0;
  int loads_refused = 0;
  int year_wraps   = 0;
  int held_days    = 0;

  calendar_date_stepper dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .start_date (start_date),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .date_out   (date_out),
    .status     (status)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Odd/even month rule; February follows the 4/100/400 leap rule.
  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m == 2) return leap ? 29 : 28;
    if (((m % 2 == 1) && m <= 7) || ((m % 2 == 0) && m >= 8)) return 31;
    return 30;
  endfunction

  // Apply one accepted item to the shadow calendar and return its result.
  task automatic step_calendar(input logic k, input logic [DATE_W-1:0] word,
                               output cal_result_t r);
    int unsigned y, m, d;
    r.date = '0;
    if (k == KIND_LOAD) begin
      y = word / 10000;
      m = (word / 100) % 100;
      d = word % 100;
      if (y > 9999 || m < 1 || m > 12 || d < 1 || d > 31) begin
        r.stat = STAT_LOAD_REJ;
        loads_refused++;
      end else begin
        cal_year  = y;
        cal_month = m;
        cal_day   = d;
        r.stat    = STAT_LOAD_OK;
        loads_taken++;
      end
    end else begin
      r.date = DATE_W'(cal_year * 10000 + cal_month * 100 + cal_day);
      r.stat = STAT_DATE;
      dates_seen++;
      if (cal_day > month_days(cal_month, cal_year)) held_days++;
      cal_day++;
      if (cal_day > month_days(cal_month, cal_year)) begin
        cal_day = 1;
        cal_month++;
        if (cal_month >= 13) begin
          cal_month = 1;
          cal_year++;
          if (cal_year > 9999) begin
            cal_year = 0;
            year_wraps++;
          end
        end
      end
    end
  endtask

  // Present one item, hold it until the transfer, then log what must come out.
  task automatic send_item(input logic k, input logic [DATE_W-1:0] word,
                           input bit typed, input cal_result_t want);
    cal_result_t predicted;
    kind       <= k;
    start_date <= word;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_calendar(k, word, predicted);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid for a cycle now and then.
  task automatic hold_off();
    if (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic plan(input logic k, input logic [DATE_W-1:0] word, input bit typed,
                      input logic [DATE_W-1:0] exp_date, input logic [1:0] exp_stat);
    script_row_t row;
    row.kind     = k;
    row.word     = word;
    row.typed    = typed;
    row.exp_date = exp_date;
    row.exp_stat = exp_stat;
    script.push_back(row);
  endtask

  // Draw one random item: mostly advances, loads mostly well formed and
  // biased toward month ends and century years so rollovers happen often.
  task automatic pick_item(output logic k, output logic [DATE_W-1:0] word);
    int unsigned s, y, m, d;
    k    = KIND_ADVANCE;
    word = DATE_W'($urandom());
    if ($urandom_range(99) < 78) return;
    k = KIND_LOAD;
    s = $urandom_range(99);
    if (s < 8) begin
      // land just before the year 9999 wrap
      word = DATE_W'(99991200 + $urandom_range(31, 27));
    end else if (s < 65) begin
      y = ($urandom_range(3) == 0) ? $urandom_range(99) * 100 : $urandom_range(9999);
      m = $urandom_range(12, 1);
      d = $urandom_range(1) ? $urandom_range(31, 1) : $urandom_range(31, 27);
      word = DATE_W'(y * 10000 + m * 100 + d);
    end else if (s < 85) begin
      // month and day over the full two-digit range, mostly out of bounds
      word = DATE_W'($urandom_range(9999) * 10000 + $urandom_range(99) * 100
                     + $urandom_range(99));
    end
  endtask

  // Receiver: stall in about one cycle out of seven, never while steady.
  always @(posedge clk) begin
    out_ready <= rst || steady || ($urandom_range(99) >= 14);
  end

  // Compare every result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    cal_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, actual date_out=%0d status=%0d",
                 $time, date_out, status);
      end else begin
        want = due_results.pop_front();
        if (status !== want.stat) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
        end
        if (date_out !== want.date) begin
          mismatches++;
          $display("%0t: date_out expected %0d actual %0d",
                   $time, want.date, date_out);
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic              k;
    logic [DATE_W-1:0] word;
    cal_result_t       want;

    // Directed script: reset date, extremes, year wrap, leap rules, held day,
    // every rejection reason.
    plan(KIND_ADVANCE, '0,           1, 27'd20000101, STAT_DATE);
    plan(KIND_LOAD,    '0,           1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd99991231, 1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, '0,           1, 27'd99991231, STAT_DATE);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);   // wrapped to year 0
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_LOAD,    '1,           1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd20240228, 1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_LOAD,    27'd19000228, 1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_LOAD,    27'd20230230, 1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);   // held day 30
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_LOAD,    27'd20231301, 1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd20230100, 1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd20230132, 1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd100000101, 1, '0, STAT_LOAD_REJ);
    plan(KIND_LOAD,    27'd20230430, 1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, 27'h5555555,  0, '0, STAT_DATE);   // payload ignored
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_LOAD,    27'd229,      1, '0, STAT_LOAD_OK);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);
    plan(KIND_ADVANCE, '0,           0, '0, STAT_DATE);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      hold_off();
      want.date = script[i].exp_date;
      want.stat = script[i].exp_stat;
      send_item(script[i].kind, script[i].word, script[i].typed, want);
    end
    wait_drained();

    // Random traffic; a stretch in the middle runs with no idling at all.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 300 && i < 500);
      if (i == 650) wait_drained();
      hold_off();
      pick_item(k, word);
      send_item(k, word, 1'b0, want);
    end
    steady = 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);

    $display("Covered %0d dates emitted, %0d loads accepted, %0d loads rejected",
             dates_seen, loads_taken, loads_refused);
    $display("Year 9999 wraps: %0d, out-of-month days emitted and rolled: %0d",
             year_wraps, held_days);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cds_pkg.sv
rtl/core/cds_front.sv
rtl/core/cds_queue.sv
rtl/core/cds_back.sv
rtl/core/calendar_date_stepper.sv
rtl/core/cds_checker.sv
test/calendar_date_stepper_test.sv
